FILE: rtl/tga_rle_pixel_decoder_top_assert.svh
// assertion macros for the tga rle pixel decoder
// all of them sample on clk and are held off while arst_n is low
`ifndef TGA_RLE_PIXEL_DECODER_TOP_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define TGARLE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tgarle check failed");

// next-cycle implication
`define TGARLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tgarle check failed");

`else

`define TGARLE_ASSERT_NOW(label, ante, cons)
`define TGARLE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/tgarle_pkg.sv
`timescale 1ns / 1ps

package tgarle_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PRESENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd3;
	localparam int CFG_DATA_W = 16;

	// packet header and pixel constants
	localparam int HDR_RUN_BIT = 7;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	// input item kinds
	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pixel_rgba;
		logic [7:0]  run_length;
		logic [31:0] first_index;
		logic        last;
		logic        overrun;
	} out_item_t;

	// settings the decode core works from
	typedef struct packed {
		logic        alpha_present;
		logic        compressed;
		logic [31:0] total_pixels;
	} dec_cfg_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} dec_res_t;

endpackage

FILE: rtl/tgarle_core.sv
`timescale 1ns / 1ps

module tgarle_core import tgarle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item_s1,
	input  dec_cfg_t cfg,
	output dec_res_t res
);

	logic        expect_header_q, expect_header_d;
	logic        packet_is_run_q, packet_is_run_d;
	logic [7:0]  pixels_left_q, pixels_left_d;
	logic [1:0]  byte_in_pixel_q, byte_in_pixel_d;
	logic [23:0] partial_q, partial_d;
	logic [31:0] pixels_done_q, pixels_done_d;
	logic        finished_q, finished_d;

	logic [31:0] remaining;
	logic        done_ge_total;
	logic        pixel_complete;
	logic [7:0]  run_n;
	logic [7:0]  left_dec;
	logic [7:0]  len;
	logic        ovr;
	logic [7:0]  red, alpha;
	logic [7:0]  b;

	assign b             = item_s1.data_byte;
	assign remaining     = cfg.total_pixels - pixels_done_q;
	assign done_ge_total = pixels_done_q >= cfg.total_pixels;

	always_comb begin
		expect_header_d = expect_header_q;
		packet_is_run_d = packet_is_run_q;
		pixels_left_d   = pixels_left_q;
		byte_in_pixel_d = byte_in_pixel_q;
		partial_d       = partial_q;
		pixels_done_d   = pixels_done_q;
		finished_d      = finished_q;
		pixel_complete  = (byte_in_pixel_q == 2'd3)
			|| (byte_in_pixel_q == 2'd2 && !cfg.alpha_present);
		red   = (byte_in_pixel_q == 2'd3) ? partial_q[23:16] : b;
		alpha = (byte_in_pixel_q == 2'd3) ? b : ALPHA_OPAQUE;
		run_n    = (pixels_left_q == 8'd0) ? 8'd1 : pixels_left_q;
		left_dec = (pixels_left_q == 8'd0) ? 8'd0 : pixels_left_q - 8'd1;
		len = 8'd1;
		ovr = 1'b0;
		res.valid = 1'b0;
		res.item.pixel_rgba  = {red, partial_q[15:8], partial_q[7:0], alpha};
		res.item.first_index = pixels_done_q;

		if (item_s1.kind == KIND_START) begin
			expect_header_d = 1'b1;
			packet_is_run_d = 1'b0;
			pixels_left_d   = 8'd0;
			byte_in_pixel_d = 2'd0;
			pixels_done_d   = 32'd0;
			finished_d      = 1'b0;
		end else if (finished_q || done_ge_total) begin
			// past the image end: byte dropped
		end else if (cfg.compressed && expect_header_q) begin
			packet_is_run_d = b[HDR_RUN_BIT];
			pixels_left_d   = {1'b0, b[HDR_RUN_BIT-1:0]} + 8'd1;
			expect_header_d = 1'b0;
		end else if (!pixel_complete) begin
			case (byte_in_pixel_q)
				2'd0:    partial_d[7:0]   = b;
				2'd1:    partial_d[15:8]  = b;
				default: partial_d[23:16] = b;
			endcase
			byte_in_pixel_d = byte_in_pixel_q + 2'd1;
		end else begin
			byte_in_pixel_d = 2'd0;
			res.valid = 1'b1;
			if (cfg.compressed && packet_is_run_q) begin
				if ({24'd0, run_n} > remaining) begin
					len = remaining[7:0];
					ovr = 1'b1;
				end else begin
					len = run_n;
				end
				expect_header_d = 1'b1;
				pixels_left_d   = 8'd0;
			end else if (cfg.compressed) begin
				ovr = (remaining == 32'd1) && (pixels_left_q > 8'd1);
				pixels_left_d = left_dec;
				if (left_dec == 8'd0) begin
					expect_header_d = 1'b1;
				end
			end
			pixels_done_d = pixels_done_q + {24'd0, len};
			// len never exceeds what is left, so the image ends exactly on equality
			finished_d = ({24'd0, len} == remaining);
		end

		res.item.run_length = len;
		res.item.last       = finished_d;
		res.item.overrun    = ovr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			packet_is_run_q <= 1'b0;
			pixels_left_q   <= 8'd0;
			byte_in_pixel_q <= 2'd0;
			pixels_done_q   <= 32'd0;
			finished_q      <= 1'b0;
		end else if (step) begin
			expect_header_q <= expect_header_d;
			packet_is_run_q <= packet_is_run_d;
			pixels_left_q   <= pixels_left_d;
			byte_in_pixel_q <= byte_in_pixel_d;
			pixels_done_q   <= pixels_done_d;
			finished_q      <= finished_d;
		end
	end

	// pixel bytes are always written before they are read
	always_ff @(posedge clk) begin
		if (step) begin
			partial_q <= partial_d;
		end
	end

endmodule

FILE: rtl/tga_rle_pixel_decoder_top.sv
// tga rle pixel decoder: an accepted input item passes the input register, the decode core and the result register
// throughput one byte item per cycle while out_stall does not hold a result, set by the single decode stage
// the input register stalls only while a finished result is held by out_stall
// arst_n clears decode state, valid flags and the registers to alpha 0, compressed 1, 1x1
// the pixel count register is recomputed from the registered width and height, so it follows a register write
`timescale 1ns / 1ps

`include "tga_rle_pixel_decoder_top_assert.svh"

module tga_rle_pixel_decoder_top import tgarle_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// byte items in
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	// run items out
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic        alpha_present_q;
	logic        compressed_q;
	logic [15:0] image_width_q;
	logic [15:0] image_height_q;
	// width times height, registered so the multiplier path ends at a register of its own
	logic [31:0] total_q;

	// input stage
	logic     s1_valid;
	in_item_t item_s1;
	logic     advance;

	// output register
	logic      out_valid_q;
	out_item_t out_item_q;

	dec_cfg_t dec_cfg;
	dec_res_t dec_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_present_q <= 1'b0;
			compressed_q    <= 1'b1;
			image_width_q   <= 16'd1;
			image_height_q  <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ALPHA_PRESENT: alpha_present_q <= cfg_data[0];
				CFG_COMPRESSED:    compressed_q    <= cfg_data[0];
				CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 32'd1;
		end else begin
			total_q <= {16'd0, image_width_q} * {16'd0, image_height_q};
		end
	end

	// the decode stage moves on whenever the output register is free or being emptied
	assign advance  = s1_valid && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	assign dec_cfg.alpha_present = alpha_present_q;
	assign dec_cfg.compressed    = compressed_q;
	assign dec_cfg.total_pixels  = total_q;

	// packet parsing, pixel assembly and run clipping
	tgarle_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item_s1 (item_s1),
		.cfg     (dec_cfg),
		.res     (dec_res)
	);

	// result register: a byte that gives no result simply empties it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= dec_res.valid;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec_res.valid) begin
			out_item_q <= dec_res.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// a clipped run always ends the image
	`TGARLE_ASSERT_NOW(a_overrun_is_last, out_valid && out_item.overrun, out_item.last)
	// a run never covers zero pixels nor more than one packet
	`TGARLE_ASSERT_NOW(a_run_len_range, out_valid,
		out_item.run_length != 8'd0 && out_item.run_length <= 8'd128)
	// the input side only stalls behind a held result
	`TGARLE_ASSERT_NOW(a_stall_cause, in_stall, s1_valid && out_valid_q && out_stall)
	// a start item never produces a result
	`TGARLE_ASSERT_NEXT(a_start_silent, advance && item_s1.kind == KIND_START, !out_valid_q)

endmodule
